### rtl/core/lspb_pkg.sv
// types, constants and helpers shared by the point bounds pipeline
package lspb_pkg;

  localparam int COORD_W         = 32;
  localparam int COEFF_W         = 16;
  localparam int AXES            = 3;
  localparam int ROW_W           = AXES * COEFF_W;
  localparam int COEFF_FRAC_BITS = 14;
  localparam int PROD_W          = COEFF_W + COORD_W;
  localparam int SUM_W           = PROD_W + 2;
  localparam int SCL_W           = SUM_W - COEFF_FRAC_BITS;
  localparam int T_W             = SCL_W + 2;
  localparam int CFG_W           = ROW_W;
  localparam int CFG_IDX_W       = 3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef prod_t [AXES-1:0]          prod_row_t;
  typedef prod_row_t [AXES-1:0]      prod_mat_t;

  localparam logic [COEFF_W-1:0] COEFF_ONE = COEFF_W'(1) << COEFF_FRAC_BITS;
  localparam row_t ROW_X_RST = {{(2*COEFF_W){1'b0}}, COEFF_ONE};
  localparam row_t ROW_Y_RST = {{COEFF_W{1'b0}}, COEFF_ONE, {COEFF_W{1'b0}}};
  localparam row_t ROW_Z_RST = {COEFF_ONE, {(2*COEFF_W){1'b0}}};

  localparam logic signed [SUM_W-1:0] ROUND_BIAS =
    {{(SUM_W-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_X   = 3'd0,
    CFG_ROW_Y   = 3'd1,
    CFG_ROW_Z   = 3'd2,
    CFG_SHIFT_X = 3'd3,
    CFG_SHIFT_Y = 3'd4,
    CFG_SHIFT_Z = 3'd5,
    CFG_NEAR    = 3'd6,
    CFG_NEGATE  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    coord_t point_z;
    logic   last_point;
  } point_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    coord_t near_bound;
    coord_t far_bound;
  } result_t;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
    coord_t min_z;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_tag_t;

  function automatic coord_t sat_coord(input logic signed [T_W-1:0] v);
    coord_t r;
    if ((v[T_W-1:COORD_W-1] == '0) || (v[T_W-1:COORD_W-1] == '1)) begin
      r = v[COORD_W-1:0];
    end else if (v[T_W-1]) begin
      r = COORD_MIN;
    end else begin
      r = COORD_MAX;
    end
    return r;
  endfunction

endpackage

### rtl/core/light_space_point_bounds.sv
// top level: config registers, input and result registers, pipeline flow control
//
//   port group | dir | beat content
//   in_        | in  | point_x, point_y, point_z, last_point
//   out_       | out | min_x, max_x, min_y, max_y, near_bound, far_bound
//   cfg_       | in  | we, index, wdata (write only, one cycle)
//
// one point per cycle sustained unless a held result stalls a last point; five register
// stages (input, products, transform, box capture, result), so a run's result is
// registered through each of these stages in turn after the beat of its last point
// synchronous reset restores the identity transform with negation, clears bounds
// a held result stalls only last points at the transform stage; other points
// keep flowing into the bounds until that stage backs up
module light_space_point_bounds (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lspb_pkg::point_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lspb_pkg::result_t                 out_data,
  input  logic                              cfg_we,
  input  logic [lspb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lspb_pkg::CFG_W-1:0]        cfg_wdata
);
  import lspb_pkg::*;

  row_t [AXES-1:0]   row_r;
  coord_t [AXES-1:0] shift_r;
  coord_t            near_off_r;
  logic              negate_r;

  logic              in_valid_r;
  point_t            in_r;
  logic              out_valid_r;
  result_t           out_r;

  stage_tag_t        tag1;
  stage_tag_t        tag2;
  stage_tag_t        tag3;
  prod_mat_t         prod;
  coord_t [AXES-1:0] pt;
  coord_t [AXES-1:0] vals;
  logic              cap_valid;
  box_t              cap_box;

  logic s1_free;
  logic s2_free;
  logic s3_free;
  logic s4_free;
  logic s5_free;
  logic bounds_step;

  logic signed [T_W-1:0] near_w;
  logic signed [T_W-1:0] far_w;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0]   <= ROW_X_RST;
      row_r[1]   <= ROW_Y_RST;
      row_r[2]   <= ROW_Z_RST;
      shift_r    <= '0;
      near_off_r <= '0;
      negate_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROW_X:   row_r[0]   <= cfg_wdata[ROW_W-1:0];
        CFG_ROW_Y:   row_r[1]   <= cfg_wdata[ROW_W-1:0];
        CFG_ROW_Z:   row_r[2]   <= cfg_wdata[ROW_W-1:0];
        CFG_SHIFT_X: shift_r[0] <= cfg_wdata[COORD_W-1:0];
        CFG_SHIFT_Y: shift_r[1] <= cfg_wdata[COORD_W-1:0];
        CFG_SHIFT_Z: shift_r[2] <= cfg_wdata[COORD_W-1:0];
        CFG_NEAR:    near_off_r <= cfg_wdata[COORD_W-1:0];
        CFG_NEGATE:  negate_r   <= cfg_wdata[0];
      endcase
    end
  end

  // flow control, back to front
  assign s5_free     = !out_valid_r || out_ready;
  assign s4_free     = !cap_valid || s5_free;
  assign s3_free     = !tag3.valid || !tag3.last || s4_free;
  assign s2_free     = !tag2.valid || s3_free;
  assign s1_free     = !in_valid_r || s2_free;
  assign bounds_step = tag3.valid && s3_free;
  assign in_ready    = s1_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (s1_free) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      in_r <= in_data;
    end
  end

  assign tag1  = '{valid: in_valid_r, last: in_r.last_point};
  assign pt[0] = in_r.point_x;
  assign pt[1] = in_r.point_y;
  assign pt[2] = in_r.point_z;

  lspb_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (s2_free),
    .up_tag (tag1),
    .pt     (pt),
    .rows   (row_r),
    .tag    (tag2),
    .prod   (prod)
  );

  lspb_xform u_xform (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (s3_free),
    .up_tag (tag2),
    .prod   (prod),
    .shift  (shift_r),
    .negate (negate_r),
    .tag    (tag3),
    .vals   (vals)
  );

  lspb_bounds u_bounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (bounds_step),
    .up_last   (tag3.last),
    .vals      (vals),
    .cap_load  (s4_free),
    .cap_valid (cap_valid),
    .cap       (cap_box)
  );

  // near and far bounds
  assign near_w = -T_W'($signed(cap_box.max_z)) - T_W'($signed(near_off_r));
  assign far_w  = -T_W'($signed(cap_box.min_z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s5_free) begin
      out_valid_r <= cap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_free && cap_valid) begin
      out_r <= '{min_x:      cap_box.min_x,
                 max_x:      cap_box.max_x,
                 min_y:      cap_box.min_y,
                 max_y:      cap_box.max_y,
                 near_bound: sat_coord(near_w),
                 far_bound:  sat_coord(far_w)};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    cap_valid |-> (($signed(cap_box.min_x) <= $signed(cap_box.max_x)) &&
                   ($signed(cap_box.min_y) <= $signed(cap_box.max_y)) &&
                   ($signed(cap_box.min_z) <= $signed(cap_box.max_z))))
    else $error("captured box has min above max");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cap_valid))
    else $error("result beat without a captured box");

  a_cap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready && cap_valid) |=> (cap_valid && $stable(cap_box)))
    else $error("captured box lost while result stalled");
`endif

endmodule

### rtl/core/lspb_mul.sv
// product stage: nine coefficient by coordinate products, registered
module lspb_mul (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         load,
  input  lspb_pkg::stage_tag_t                         up_tag,
  input  lspb_pkg::coord_t [lspb_pkg::AXES-1:0]        pt,
  input  lspb_pkg::row_t [lspb_pkg::AXES-1:0]          rows,
  output lspb_pkg::stage_tag_t                         tag,
  output lspb_pkg::prod_mat_t                          prod
);
  import lspb_pkg::*;

  stage_tag_t tag_r;
  prod_mat_t  prod_r;
  prod_mat_t  prod_nxt;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      for (int k = 0; k < AXES; k++) begin
        prod_nxt[a][k] = $signed(rows[a][k*COEFF_W +: COEFF_W]) * $signed(pt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (load) begin
      tag_r <= up_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

  assign tag  = tag_r;
  assign prod = prod_r;

endmodule

### rtl/core/lspb_xform.sv
// transform stage: sum, round, translate, optionally negate and saturate per axis
module lspb_xform (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  lspb_pkg::stage_tag_t                  up_tag,
  input  lspb_pkg::prod_mat_t                   prod,
  input  lspb_pkg::coord_t [lspb_pkg::AXES-1:0] shift,
  input  logic                                  negate,
  output lspb_pkg::stage_tag_t                  tag,
  output lspb_pkg::coord_t [lspb_pkg::AXES-1:0] vals
);
  import lspb_pkg::*;

  stage_tag_t              tag_r;
  coord_t [AXES-1:0]       vals_r;
  coord_t [AXES-1:0]       vals_nxt;
  logic signed [SUM_W-1:0] acc     [AXES];
  logic signed [SUM_W-1:0] rounded [AXES];
  logic signed [SCL_W-1:0] scaled  [AXES];
  logic signed [T_W-1:0]   t_sum   [AXES];
  logic signed [T_W-1:0]   t_sel   [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      acc[a] = '0;
      for (int k = 0; k < AXES; k++) begin
        acc[a] = acc[a] + SUM_W'($signed(prod[a][k]));
      end
      rounded[a]  = acc[a] + ROUND_BIAS;
      scaled[a]   = $signed(rounded[a][SUM_W-1:COEFF_FRAC_BITS]);
      t_sum[a]    = T_W'(scaled[a]) + T_W'($signed(shift[a]));
      t_sel[a]    = negate ? -t_sum[a] : t_sum[a];
      vals_nxt[a] = sat_coord(t_sel[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (load) begin
      tag_r <= up_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vals_r <= vals_nxt;
    end
  end

  assign tag  = tag_r;
  assign vals = vals_r;

endmodule

### rtl/core/lspb_bounds.sv
// running per-axis bounds and capture of the finished box on the last point
module lspb_bounds (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  step,
  input  logic                                  up_last,
  input  lspb_pkg::coord_t [lspb_pkg::AXES-1:0] vals,
  input  logic                                  cap_load,
  output logic                                  cap_valid,
  output lspb_pkg::box_t                        cap
);
  import lspb_pkg::*;

  coord_t [AXES-1:0] low_r;
  coord_t [AXES-1:0] high_r;
  coord_t [AXES-1:0] low_nxt;
  coord_t [AXES-1:0] high_nxt;
  logic              run_r;
  logic              cap_valid_r;
  box_t              cap_r;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      low_nxt[a]  = (!run_r || ($signed(vals[a]) < $signed(low_r[a]))) ? vals[a] : low_r[a];
      high_nxt[a] = (!run_r || ($signed(vals[a]) > $signed(high_r[a]))) ? vals[a] : high_r[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r       <= '0;
      high_r      <= '0;
      run_r       <= 1'b0;
      cap_valid_r <= 1'b0;
    end else begin
      if (step) begin
        low_r  <= low_nxt;
        high_r <= high_nxt;
        run_r  <= !up_last;
      end
      if (cap_load) begin
        cap_valid_r <= step && up_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cap_load) begin
      cap_r <= '{min_x: low_nxt[0], max_x: high_nxt[0],
                 min_y: low_nxt[1], max_y: high_nxt[1],
                 min_z: low_nxt[2], max_z: high_nxt[2]};
    end
  end

  assign cap_valid = cap_valid_r;
  assign cap       = cap_r;

endmodule

### bench/testbench.sv
// self-checking bench for the transformed point bounding box block
module testbench;
  import lspb_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  class point_bounds_board;
    row_t            rows [3];
    longint          shifts [3];
    longint          near_off;
    bit              negate;
    coord_t          lo [3];
    coord_t          hi [3];
    bit              started;
    result_t         pending_boxes [$];
    int              errors;

    function new();
      rows[0]  = ROW_X_RST;
      rows[1]  = ROW_Y_RST;
      rows[2]  = ROW_Z_RST;
      shifts   = '{0, 0, 0};
      near_off = 0;
      negate   = 1'b1;
      lo       = '{0, 0, 0};
      hi       = '{0, 0, 0};
      started  = 1'b0;
      errors   = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
      coord_t c;
      c = v[COORD_W-1:0];
      case (idx) inside
        CFG_ROW_X, CFG_ROW_Y, CFG_ROW_Z: begin
          rows[int'(idx) - int'(CFG_ROW_X)] = v;
        end
        CFG_SHIFT_X, CFG_SHIFT_Y, CFG_SHIFT_Z: begin
          shifts[int'(idx) - int'(CFG_SHIFT_X)] = longint'(c);
        end
        CFG_NEAR: begin
          near_off = longint'(c);
        end
        CFG_NEGATE: begin
          negate = v[0];
        end
        default: begin
        end
      endcase
    endfunction

    function coord_t clamp(longint v);
      if (v > longint'(COORD_MAX)) return COORD_MAX;
      if (v < longint'(COORD_MIN)) return COORD_MIN;
      return coord_t'(v);
    endfunction

    function coord_t transform(int a, point_t p);
      coord_t               pt [3];
      logic signed [15:0]   c;
      longint               acc;
      pt[0] = p.point_x;
      pt[1] = p.point_y;
      pt[2] = p.point_z;
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        c = rows[a][16*k +: 16];
        acc += longint'(c) * longint'(pt[k]);
      end
      acc = (acc + (longint'(1) << (COEFF_FRAC_BITS - 1))) >>> COEFF_FRAC_BITS;
      acc = acc + shifts[a];
      if (negate) acc = -acc;
      return clamp(acc);
    endfunction

    function void take_point(point_t p);
      coord_t  v [3];
      result_t r;
      for (int a = 0; a < 3; a++) v[a] = transform(a, p);
      for (int a = 0; a < 3; a++) begin
        if (!started) begin
          lo[a] = v[a];
          hi[a] = v[a];
        end else begin
          if (v[a] < lo[a]) lo[a] = v[a];
          if (v[a] > hi[a]) hi[a] = v[a];
        end
      end
      if (!p.last_point) begin
        started = 1'b1;
      end else begin
        started      = 1'b0;
        r.min_x      = lo[0];
        r.max_x      = hi[0];
        r.min_y      = lo[1];
        r.max_y      = hi[1];
        r.near_bound = clamp(-longint'(hi[2]) - near_off);
        r.far_bound  = clamp(-longint'(lo[2]));
        pending_boxes = {pending_boxes, r};
      end
    endfunction

    function void check_field(string fname, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s expected %0d got %0d", fname, want, got);
        errors++;
      end
    endfunction

    function void match_box(result_t got);
      result_t want;
      if (pending_boxes.size() == 0) begin
        $error("result beat with no expected box");
        errors++;
        return;
      end
      want = pending_boxes.pop_front();
      check_field("min_x", want.min_x, got.min_x);
      check_field("max_x", want.max_x, got.max_x);
      check_field("min_y", want.min_y, got.min_y);
      check_field("max_y", want.max_y, got.max_y);
      check_field("near_bound", want.near_bound, got.near_bound);
      check_field("far_bound", want.far_bound, got.far_bound);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  point_t               in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_t              out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  point_bounds_board board = new();
  int send_idle_pct;
  int stall_pct;
  int quiet_cycles = 0;

  light_space_point_bounds DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.take_point(in_data);
    if (rst_n && out_valid && out_ready) board.match_box(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[light_space_point_bounds] ERROR");
      $finish;
    end
  end

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(7)) inside
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3, 4: return 16'($urandom_range(32767) - 16384);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(9)) inside
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3, 4: return coord_t'(int'($urandom_range(2097152)) - 1048576);
      default: return coord_t'($urandom());
    endcase
  endfunction

  // entered and left at a falling edge; valid stays high unless an idle cycle is taken
  task automatic send_point(point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_xyz(coord_t x, coord_t y, coord_t z, logic last);
    point_t p;
    p.point_x    = x;
    p.point_y    = y;
    p.point_z    = z;
    p.last_point = last;
    send_point(p);
  endtask

  task automatic send_run(int len);
    for (int i = 0; i < len; i++) send_xyz(pick_coord(), pick_coord(), pick_coord(), i == len - 1);
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (board.pending_boxes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic load_random_setup();
    put_reg(CFG_ROW_X, {pick_coeff(), pick_coeff(), pick_coeff()});
    put_reg(CFG_ROW_Y, {pick_coeff(), pick_coeff(), pick_coeff()});
    put_reg(CFG_ROW_Z, {pick_coeff(), pick_coeff(), pick_coeff()});
    put_reg(CFG_SHIFT_X, CFG_W'(pick_coord()));
    put_reg(CFG_SHIFT_Y, CFG_W'(pick_coord()));
    put_reg(CFG_SHIFT_Z, CFG_W'(pick_coord()));
    put_reg(CFG_NEAR, CFG_W'(pick_coord()));
    put_reg(CFG_NEGATE, CFG_W'({$urandom(), $urandom()}));
  endtask

  initial begin
    int sent;
    int len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_ROW_X;
    cfg_wdata     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset setup: identity with negation, single-point runs and a short run
    send_xyz(COORD_MAX, COORD_MIN, '0, 1'b1);
    send_xyz(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);
    send_xyz(32'sd1, -32'sd1, 32'sh0000_8000, 1'b0);
    send_xyz(-32'sd65536, 32'sd65536, 32'sd12345, 1'b0);
    send_xyz('0, '0, '0, 1'b1);
    settle();

    // saturating setup: largest products, far and near bounds clip
    put_reg(CFG_ROW_X, 48'h7FFF_7FFF_7FFF);
    put_reg(CFG_ROW_Y, 48'h8000_8000_8000);
    put_reg(CFG_ROW_Z, CFG_W'(ROW_Z_RST));
    put_reg(CFG_SHIFT_X, CFG_W'(COORD_MIN));
    put_reg(CFG_SHIFT_Y, CFG_W'(COORD_MAX));
    put_reg(CFG_SHIFT_Z, CFG_W'(COORD_MAX));
    put_reg(CFG_NEAR, CFG_W'(COORD_MIN));
    put_reg(CFG_NEGATE, 48'hFFFF_FFFF_FFFF);
    send_xyz(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    send_xyz(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_xyz(COORD_MAX, COORD_MIN, '0, 1'b0);
    send_xyz(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0, 1'b1);
    settle();

    // no negation, upper bits of the negate write set
    put_reg(CFG_ROW_X, 48'h8000_8000_8000);
    put_reg(CFG_ROW_Y, 48'h7FFF_7FFF_7FFF);
    put_reg(CFG_ROW_Z, 48'h8000_7FFF_0001);
    put_reg(CFG_SHIFT_X, CFG_W'(COORD_MAX));
    put_reg(CFG_SHIFT_Y, CFG_W'(COORD_MIN));
    put_reg(CFG_SHIFT_Z, CFG_W'(COORD_MIN));
    put_reg(CFG_NEAR, CFG_W'(COORD_MAX));
    put_reg(CFG_NEGATE, 48'hFFFF_FFFF_FFFE);
    send_xyz(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1);
    send_xyz(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_xyz(-32'sd1, 32'sd1, -32'sd1, 1'b0);
    send_xyz(32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_0F0F, 1'b1);
    settle();

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 69;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 69;
        end
        default: begin
          send_idle_pct = 14;
          stall_pct     = 14;
        end
      endcase
      load_random_setup();
      sent = 0;
      while (sent < 105) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
        send_run(len);
        sent += len;
      end
      settle();
    end

    if (board.errors == 0 && board.pending_boxes.size() == 0) begin
      $display("[light_space_point_bounds] OK");
    end else begin
      $display("[light_space_point_bounds] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/lspb_pkg.sv
rtl/core/lspb_mul.sv
rtl/core/lspb_xform.sv
rtl/core/lspb_bounds.sv
rtl/core/light_space_point_bounds.sv
bench/testbench.sv
